FILE: hw/rtl/tadc_pkg.sv
// Package for the thermistor ADC to deci-Celsius converter.
// Holds widths, item and tag types, and the ln fraction table; no dependencies.
`timescale 1ns / 1ps

package tadc_pkg;

  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned MV_W         = 12;
  localparam int unsigned TEMP_W       = 17;
  localparam int unsigned TYPES_W      = 16;

  localparam int unsigned NUM_W = 54;
  localparam int unsigned DEN_W = 36;
  localparam int unsigned QUO_W = 26;

  localparam logic [1:0] TYPE_NTC = 2'd0;
  localparam logic [1:0] TYPE_RTD = 2'd1;

  localparam logic [MV_W-1:0] NTC_SUPPLY_MV = 12'd3300;

  typedef enum logic [1:0] {
    KIND_NTC,
    KIND_RTD,
    KIND_RAW
  } kind_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [MV_W-1:0] mv;
    kind_e           kind;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [MV_W-1:0] mv;
    kind_e           kind;
    logic            sat_lo;
    logic            sat_hi;
    logic            neg;
  } tag_t;

  function automatic logic [15:0] ln_frac(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41196;
      5'd15:   v = 16'd43345;
      5'd16:   v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/tadc_front.sv
// Front end of the converter: takes items, drops failed reads, classifies by channel type.
// Depends on tadc_pkg.
`timescale 1ns / 1ps

module tadc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [tadc_pkg::CH_W-1:0]       channel_i,
  input  logic [tadc_pkg::MV_W-1:0]       reading_mv_i,
  input  logic                            adc_ok_i,
  input  logic [tadc_pkg::TYPES_W-1:0]    types_i,
  input  logic                            full_i,
  output logic                            push_o,
  output tadc_pkg::item_t                 item_o
);

  logic            valid_q, valid_d;
  tadc_pkg::item_t item_q;
  logic            accept, keep;
  logic [1:0]      ch_type;
  tadc_pkg::kind_e kind;

  assign busy   = valid_q & full_i;
  assign push_o = valid_q & ~full_i;
  assign item_o = item_q;
  assign accept = start & ~busy;

  assign keep    = adc_ok_i & ({1'b0, channel_i} < 4'(tadc_pkg::NUM_CHANNELS));
  assign ch_type = types_i[{channel_i, 1'b0} +: 2];

  always_comb begin
    case (ch_type)
      tadc_pkg::TYPE_NTC: kind = tadc_pkg::KIND_NTC;
      tadc_pkg::TYPE_RTD: kind = tadc_pkg::KIND_RTD;
      default:            kind = tadc_pkg::KIND_RAW;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = keep;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.ch   <= channel_i;
      item_q.mv   <= reading_mv_i;
      item_q.kind <= kind;
    end
  end

endmodule

FILE: hw/rtl/tadc_queue.sv
// Two-entry queue between the front end and the conversion pipeline.
// Depends on tadc_pkg.
`timescale 1ns / 1ps

module tadc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tadc_pkg::item_t item_i,
  output logic            full_o,
  output logic            pop_o,
  output tadc_pkg::item_t item_o
);

  tadc_pkg::item_t mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      count_q, count_d;

  assign full_o = (count_q == 2'd2);
  assign pop_o  = (count_q != 2'd0);
  assign item_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_o) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

FILE: hw/rtl/tadc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Depends on tadc_pkg.
`timescale 1ns / 1ps

module tadc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [tadc_pkg::NUM_W-1:0]    num_i,
  input  logic [tadc_pkg::DEN_W-1:0]    den_i,
  input  tadc_pkg::tag_t                tag_i,
  output logic                          valid_o,
  output logic [tadc_pkg::QUO_W-1:0]    quo_o,
  output tadc_pkg::tag_t                tag_o
);

  localparam int unsigned DW = tadc_pkg::DEN_W;
  localparam int unsigned QW = tadc_pkg::QUO_W;

  logic           valid_q [QW];
  logic [DW-1:0]  rem_q   [QW];
  logic [DW-1:0]  den_q   [QW];
  logic [QW-1:0]  low_q   [QW];
  logic [QW-1:0]  quo_q   [QW];
  tadc_pkg::tag_t tag_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           v_src;
    logic [DW-1:0]  rem_src, den_src;
    logic [QW-1:0]  low_src, quo_src;
    tadc_pkg::tag_t tag_src;
    logic [DW:0]    trial, diff;

    if (k == 0) begin : g_first
      assign v_src   = valid_i;
      assign rem_src = DW'(num_i[tadc_pkg::NUM_W-1:QW]);
      assign den_src = den_i;
      assign low_src = num_i[QW-1:0];
      assign quo_src = '0;
      assign tag_src = tag_i;
    end else begin : g_next
      assign v_src   = valid_q[k-1];
      assign rem_src = rem_q[k-1];
      assign den_src = den_q[k-1];
      assign low_src = low_q[k-1];
      assign quo_src = quo_q[k-1];
      assign tag_src = tag_q[k-1];
    end

    assign trial = {rem_src, low_src[QW-1]};
    assign diff  = trial - {1'b0, den_src};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      quo_q[k] <= {quo_src[QW-2:0], ~diff[DW]};
      low_q[k] <= {low_src[QW-2:0], 1'b0};
      den_q[k] <= den_src;
      tag_q[k] <= tag_src;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

FILE: hw/rtl/tadc_back.sv
// Conversion pipeline: ln by table and interpolation, beta and RTD terms, division, scaling.
// Depends on tadc_pkg and tadc_div.
`timescale 1ns / 1ps

module tadc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  tadc_pkg::item_t                item_i,
  output logic                           result_valid_o,
  output logic [tadc_pkg::CH_W-1:0]      channel_out_o,
  output logic signed [tadc_pkg::TEMP_W-1:0] temperature_o,
  output logic                           out_of_range_o
);

  localparam logic [16:0] LN2_Q16      = 17'd45426;
  localparam logic signed [20:0] LN056 = 21'sd37999;
  localparam logic signed [36:0] DEN_OFS = 37'sd22465740800;
  localparam logic [tadc_pkg::NUM_W-1:0] NTC_NUM =
    tadc_pkg::NUM_W'(64'd1022058200 << 24);

  typedef struct packed {
    logic [3:0]  e;
    logic [15:0] lo;
    logic [11:0] diff;
    logic [11:0] rem;
  } ln_t;

  typedef struct packed {
    tadc_pkg::tag_t     tag;
    ln_t                la;
    ln_t                lb;
    logic signed [18:0] a;
    logic [16:0]        b;
  } s1_t;

  typedef struct packed {
    tadc_pkg::tag_t     tag;
    logic signed [20:0] lnx;
    logic [34:0]        mag;
    logic [23:0]        bot;
  } s2_t;

  typedef struct packed {
    tadc_pkg::tag_t  tag;
    logic [35:0]     den;
    logic [34:0]     mag;
    logic [23:0]     bot;
  } s3_t;

  function automatic ln_t ln_prep(input logic [11:0] n);
    ln_t         r;
    logic [11:0] nn, norm;
    logic [3:0]  e;
    logic [15:0] hi;
    nn = (n == 12'd0) ? 12'd1 : n;
    e  = 4'd0;
    for (int b = 1; b < 12; b++) begin
      if (nn[b]) begin
        e = 4'(b);
      end
    end
    norm   = nn << (4'd11 - e);
    r.e    = e;
    r.lo   = tadc_pkg::ln_frac({1'b0, norm[10:7]});
    hi     = tadc_pkg::ln_frac({1'b0, norm[10:7]} + 5'd1);
    r.diff = 12'(hi - r.lo);
    r.rem  = {norm[6:0], 5'b0};
    return r;
  endfunction

  function automatic logic [19:0] ln_sum(input ln_t l);
    logic [23:0] prod;
    prod = 24'(l.diff) * 24'(l.rem);
    return 20'(l.e) * 20'(LN2_Q16) + 20'(l.lo) + 20'(prod[23:12]);
  endfunction

  logic s1_v_q, s2_v_q, s3_v_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;

  logic signed [37:0] top;
  logic [19:0]        lna, lnb;
  logic signed [36:0] den_full;
  logic               den_bad;

  logic                             div_v;
  logic                             div_v_out;
  logic [tadc_pkg::NUM_W-1:0]       div_num;
  logic [tadc_pkg::DEN_W-1:0]       div_den;
  logic [tadc_pkg::QUO_W-1:0]       quo;
  tadc_pkg::tag_t                   qtag;

  logic signed [26:0]               tk_ofs, tk_adj, tk_shr;
  logic [tadc_pkg::TEMP_W-1:0]      rq;
  logic [tadc_pkg::TEMP_W-1:0]      temp_d;
  logic                             oor_d;

  logic                             res_v_q;
  logic [tadc_pkg::CH_W-1:0]        ch_q;
  logic [tadc_pkg::TEMP_W-1:0]      temp_q;
  logic                             oor_q;

  always_comb begin
    s1_d.tag.ch     = item_i.ch;
    s1_d.tag.mv     = item_i.mv;
    s1_d.tag.kind   = item_i.kind;
    s1_d.tag.sat_lo = item_i.mv >= tadc_pkg::NTC_SUPPLY_MV;
    s1_d.tag.sat_hi = item_i.mv == 12'd0;
    s1_d.tag.neg    = 1'b0;
    s1_d.la         = ln_prep(item_i.mv);
    s1_d.lb         = ln_prep(tadc_pkg::NTC_SUPPLY_MV - item_i.mv);
    s1_d.a          = $signed({1'b0, 18'(item_i.mv) * 18'd34}) - 19'sd87450;
    s1_d.b          = 17'd87450 - 17'(item_i.mv);
  end

  always_comb begin
    lna          = ln_sum(s1_q.la);
    lnb          = ln_sum(s1_q.lb);
    top          = $signed({{19{s1_q.a[18]}}, s1_q.a}) * 38'sd200000;
    s2_d.tag     = s1_q.tag;
    s2_d.tag.neg = top[37];
    s2_d.lnx     = $signed({1'b0, lna}) - $signed({1'b0, lnb}) - LN056;
    s2_d.mag     = top[37] ? 35'(-top) : top[34:0];
    s2_d.bot     = 24'(s1_q.b) * 24'd77;
  end

  always_comb begin
    den_full = $signed({{16{s2_q.lnx[20]}}, s2_q.lnx}) * 37'sd29815 + DEN_OFS;
    den_bad  = den_full[36] | (den_full == 37'sd0);
    s3_d     = '0;
    s3_d.tag = s2_q.tag;
    s3_d.tag.sat_hi = s2_q.tag.sat_hi | den_bad;
    s3_d.den = den_full[35:0];
    s3_d.mag = s2_q.mag;
    s3_d.bot = s2_q.bot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  assign div_v   = s3_v_q;
  assign div_num = (s3_q.tag.kind == tadc_pkg::KIND_NTC) ? NTC_NUM
                                                        : tadc_pkg::NUM_W'(s3_q.mag);
  assign div_den = (s3_q.tag.kind == tadc_pkg::KIND_NTC) ? s3_q.den
                                                        : tadc_pkg::DEN_W'(s3_q.bot);

  tadc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .num_i   (div_num),
    .den_i   (div_den),
    .tag_i   (s3_q.tag),
    .valid_o (div_v_out),
    .quo_o   (quo),
    .tag_o   (qtag)
  );

  always_comb begin
    tk_ofs = $signed({1'b0, quo}) - 27'sd699264;
    tk_adj = tk_ofs + (tk_ofs[26] ? 27'sd255 : 27'sd0);
    tk_shr = tk_adj >>> 8;
    rq     = tadc_pkg::TEMP_W'(quo);
    oor_d  = 1'b0;
    case (qtag.kind)
      tadc_pkg::KIND_NTC: begin
        if (qtag.sat_lo) begin
          temp_d = 17'h1F555;
          oor_d  = 1'b1;
        end else if (qtag.sat_hi) begin
          temp_d = 17'd65535;
          oor_d  = 1'b1;
        end else begin
          temp_d = tk_shr[16:0];
        end
      end
      tadc_pkg::KIND_RTD: begin
        temp_d = qtag.neg ? -rq : rq;
      end
      default: begin
        temp_d = tadc_pkg::TEMP_W'(qtag.mv);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= div_v_out;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= qtag.ch;
    temp_q <= temp_d;
    oor_q  <= oor_d;
  end

  assign result_valid_o = res_v_q;
  assign channel_out_o  = ch_q;
  assign temperature_o  = $signed(temp_q);
  assign out_of_range_o = oor_q;

endmodule

FILE: hw/rtl/thermistor_adc_to_decicelsius_unit.sv
// Top level of the thermistor ADC to deci-Celsius converter: register port and wiring.
// Depends on tadc_pkg, tadc_front, tadc_queue and tadc_back.
// Takes one reading per cycle while busy is low.
// The divider is a 26-stage pipeline; results cannot be held off.
// Reset is asynchronous and active low; it empties the pipeline and clears channel_types.
`timescale 1ns / 1ps

module thermistor_adc_to_decicelsius_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [tadc_pkg::CH_W-1:0]          channel_i,
  input  logic [tadc_pkg::MV_W-1:0]          reading_mv_i,
  input  logic                               adc_ok_i,
  output logic                               result_valid_o,
  output logic [tadc_pkg::CH_W-1:0]          channel_out_o,
  output logic signed [tadc_pkg::TEMP_W-1:0] temperature_o,
  output logic                               out_of_range_o
);

  logic [tadc_pkg::TYPES_W-1:0] types_q;
  logic                         full, push, pop;
  tadc_pkg::item_t              f_item, q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'b0, types_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      types_q <= pwdata[15:0];
    end
  end

  tadc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .channel_i    (channel_i),
    .reading_mv_i (reading_mv_i),
    .adc_ok_i     (adc_ok_i),
    .types_i      (types_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (f_item)
  );

  tadc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_o  (pop),
    .item_o (q_item)
  );

  tadc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (pop),
    .item_i         (q_item),
    .result_valid_o (result_valid_o),
    .channel_out_o  (channel_out_o),
    .temperature_o  (temperature_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: verif/tb_thermistor_adc_to_decicelsius_unit.sv
// Testbench for thermistor_adc_to_decicelsius_unit: drives readings and register writes,
// predicts every conversion and checks each result strobe against it.
// Depends on tadc_pkg and the RTL of the converter.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  ch;
  logic [16:0] temp;
  logic        oor;
} temp_reading_t;

class temp_scoreboard;
  logic [15:0]   channel_types;
  temp_reading_t pending_q[$];
  int            mismatches;

  function new();
    channel_types = '0;
    mismatches    = 0;
  endfunction

  function automatic longint ln_q16(int unsigned n);
    int        ln_tab[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                              29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
    int unsigned e, f, frac, idx, rem, step;
    n = n & 32'hFFF;
    if (n == 0) begin
      n = 1;
    end
    e = 0;
    while (e < 11 && (n >> (e + 1)) != 0) e++;
    f    = (n << 16) >> e;
    frac = f - 65536;
    idx  = (frac >> 12) & 15;
    rem  = frac & 12'hFFF;
    step = ((ln_tab[idx + 1] - ln_tab[idx]) * rem) >> 12;
    return longint'(e) * 45426 + ln_tab[idx] + step;
  endfunction

  function automatic longint ntc_decicelsius(int unsigned mv, output logic oor);
    longint lnx, den, tk;
    oor = 1'b1;
    if (mv >= 3300) begin
      return -2731;
    end
    if (mv == 0) begin
      return 65535;
    end
    lnx = -37999 + ln_q16(mv) - ln_q16(3300 - mv);
    den = 64'sd29815 * lnx + 64'sd342800 * 65536;
    if (den <= 0) begin
      return 65535;
    end
    oor = 1'b0;
    tk  = (64'sd10220582 * 100 * 65536 * 256) / den;
    return (tk - 699264) / 256;
  endfunction

  function void note_reading(logic [2:0] ch, logic [11:0] mv, logic ok);
    temp_reading_t r;
    logic [1:0]    kind;
    longint        t;
    if (!ok || ch >= tadc_pkg::NUM_CHANNELS) begin
      return;
    end
    kind  = channel_types[2*ch +: 2];
    r.ch  = ch;
    r.oor = 1'b0;
    if (kind == tadc_pkg::TYPE_NTC) begin
      t = ntc_decicelsius(mv, r.oor);
    end else if (kind == tadc_pkg::TYPE_RTD) begin
      t = (64'sd200000 * (64'sd34 * longint'(mv) - 87450)) /
          (64'sd77 * (87450 - longint'(mv)));
    end else begin
      t = mv;
    end
    r.temp = t[16:0];
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [2:0] ch, logic [16:0] temp, logic oor);
    temp_reading_t r;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result: ch %0d temp %0h oor %0b", ch, temp, oor);
      end
      return;
    end
    r = pending_q.pop_front();
    if (r.ch !== ch || r.temp !== temp || r.oor !== oor) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch: expected ch %0d temp %0h oor %0b, got ch %0d temp %0h oor %0b",
                 r.ch, r.temp, r.oor, ch, temp, oor);
      end
    end
  endfunction
endclass

module tb_thermistor_adc_to_decicelsius_unit;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;
  logic              start, busy;
  logic [tadc_pkg::CH_W-1:0]   channel_i;
  logic [tadc_pkg::MV_W-1:0]   reading_mv_i;
  logic              adc_ok_i;
  logic              result_valid_o;
  logic [tadc_pkg::CH_W-1:0]   channel_out_o;
  logic signed [tadc_pkg::TEMP_W-1:0] temperature_o;
  logic              out_of_range_o;

  temp_scoreboard sb;
  bit             no_idle;

  thermistor_adc_to_decicelsius_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      sb.note_reading(channel_i, reading_mv_i, adc_ok_i);
    end
    if (rst_ni && result_valid_o) begin
      sb.check_result(channel_out_o, temperature_o, out_of_range_o);
    end
  end

  task automatic write_types(logic [15:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.channel_types = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_reading(logic [2:0] ch, logic [11:0] mv, logic ok);
    logic b;
    start        <= 1'b1;
    channel_i    <= ch;
    reading_mv_i <= mv;
    adc_ok_i     <= ok;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
    if (!no_idle && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [11:0] mv;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0:       mv = 12'($urandom_range(4095));
        1:       mv = 12'($urandom_range(3299, 1));
        2:       mv = 12'($urandom_range(200, 0));
        default: mv = 12'($urandom_range(3400, 3100));
      endcase
      send_reading(3'($urandom_range(7)), mv, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    logic [15:0] phase_types[6];
    logic [11:0] edge_mv[6];
    phase_types = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hE4E4, 16'h1B1B};
    edge_mv     = '{12'd0, 12'd1, 12'd1650, 12'd3299, 12'd3300, 12'd4095};
    sb      = new();
    no_idle = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    channel_i    = '0;
    reading_mv_i = '0;
    adc_ok_i     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 6; k++) begin
      send_reading(3'(k), edge_mv[k], 1'b1);
    end
    send_reading(3'd7, 12'd1000, 1'b0);
    drain();
    write_types(16'hE4E4);
    for (int k = 0; k < 16; k++) begin
      send_reading(3'(k % 8), edge_mv[k % 6], 1'b1);
    end
    drain();

    for (int p = 0; p < 7; p++) begin
      write_types(p < 6 ? phase_types[p] : 16'($urandom));
      no_idle = (p == 2);
      send_random(135);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
